// ----- src/cgc_pkg.sv -----
package cgc_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_BITS  = COORD_BITS + 1;        // signed coordinate difference
	localparam int PROD_BITS  = 2 * DIFF_BITS;         // signed product
	localparam int SUM_BITS   = PROD_BITS + 1;         // signed sum of two products
	localparam int LEN_BITS   = 2 * COORD_BITS + 1;    // unsigned squared length
	localparam int MAG_BITS   = COORD_BITS;            // |d| magnitude
	localparam int REM_BITS   = LEN_BITS + 1;
	localparam int DIST_BITS  = 2 * COORD_BITS + 1;
	localparam int CFG_BITS   = COORD_BITS;
	localparam int IDX_BITS   = 3;
	localparam int CNT_BITS   = 3;
	localparam int NUM_EDGES  = 3;

	// one cell per quotient bit of the scaled divide
	localparam int DIV_CELLS  = MAG_BITS;

	localparam logic [IDX_BITS-1:0] REG_SOURCE_COUNT = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_FIRST_X      = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_FIRST_Y      = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_SECOND_X     = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_SECOND_Y     = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_THIRD_X      = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_THIRD_Y      = 3'd6;

	localparam logic [1:0] ST_INSIDE  = 2'd0;
	localparam logic [1:0] ST_EDGE    = 2'd1;
	localparam logic [1:0] ST_SEGMENT = 2'd2;
	localparam logic [1:0] ST_UNSUP   = 2'd3;

	localparam logic [CNT_BITS-1:0] CNT_SEGMENT  = 3'd2;
	localparam logic [CNT_BITS-1:0] CNT_TRIANGLE = 3'd3;

	typedef struct packed {
		logic [COORD_BITS-1:0] target_x;
		logic [COORD_BITS-1:0] target_y;
	} in_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] clipped_x;
		logic [COORD_BITS-1:0] clipped_y;
		logic [1:0]            clip_status;
	} out_item_t;

	// per-axis divide work handed along the chain
	typedef struct packed {
		logic [MAG_BITS-1:0] mag;   // |d|, consumed MSB first
		logic                neg;
		logic [LEN_BITS-1:0] num;   // dot
		logic [LEN_BITS-1:0] den;   // len2
		logic [REM_BITS-1:0] rem;
		logic [MAG_BITS:0]   q;
		logic [COORD_BITS-1:0] base;
		logic                fixed; // result already settled as base
	} axis_work_t;

	typedef struct packed {
		axis_work_t wx;
		axis_work_t wy;
	} edge_work_t;

	// context that rides next to the divide chain
	typedef struct packed {
		logic [COORD_BITS-1:0] tx;
		logic [COORD_BITS-1:0] ty;
		logic [1:0]            status;
		logic                  in_tri;
	} ctx_t;

endpackage

// ----- src/cgc_div_cell.sv -----
module cgc_div_cell
	import cgc_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  edge_work_t w_in [NUM_EDGES],
	input  ctx_t       c_in,
	output edge_work_t w_out [NUM_EDGES],
	output ctx_t       c_out
);

	function automatic axis_work_t step(axis_work_t a);
		axis_work_t r;
		logic [REM_BITS-1:0] rm;
		logic [MAG_BITS:0] qq;
		r  = a;
		rm = {a.rem[REM_BITS-2:0], 1'b0};
		qq = {a.q[MAG_BITS-1:0], 1'b0};
		if (rm >= {1'b0, a.den}) begin
			rm = rm - {1'b0, a.den};
			qq = qq + 1'b1;
		end
		if (a.mag[MAG_BITS-1]) begin
			rm = rm + {1'b0, a.num};
			if (rm >= {1'b0, a.den}) begin
				rm = rm - {1'b0, a.den};
				qq = qq + 1'b1;
			end
		end
		r.rem = rm;
		r.q   = qq;
		r.mag = {a.mag[MAG_BITS-2:0], 1'b0};
		return r;
	endfunction

	edge_work_t w_q [NUM_EDGES];
	ctx_t       c_q;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NUM_EDGES; e++) begin
				w_q[e].wx <= step(w_in[e].wx);
				w_q[e].wy <= step(w_in[e].wy);
			end
			c_q <= c_in;
		end
	end

	assign w_out = w_q;
	assign c_out = c_q;

endmodule

// ----- src/cgc_front.sv -----
module cgc_front
	import cgc_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  in_item_t              item,
	input  logic [CNT_BITS-1:0]   source_count,
	input  logic [COORD_BITS-1:0] px [NUM_EDGES],
	input  logic [COORD_BITS-1:0] py [NUM_EDGES],
	output edge_work_t            w_out [NUM_EDGES],
	output ctx_t                  c_out
);

	// stage 1: differences and products
	logic signed [PROD_BITS-1:0] dxvx_s1 [NUM_EDGES];
	logic signed [PROD_BITS-1:0] dyvy_s1 [NUM_EDGES];
	logic        [PROD_BITS-1:0] dxdx_s1 [NUM_EDGES];
	logic        [PROD_BITS-1:0] dydy_s1 [NUM_EDGES];
	logic signed [PROD_BITS-1:0] cra_s1  [NUM_EDGES];
	logic signed [PROD_BITS-1:0] crb_s1  [NUM_EDGES];
	logic signed [DIFF_BITS-1:0] dx_s1   [NUM_EDGES];
	logic signed [DIFF_BITS-1:0] dy_s1   [NUM_EDGES];
	logic [COORD_BITS-1:0] p1x_s1 [NUM_EDGES];
	logic [COORD_BITS-1:0] p1y_s1 [NUM_EDGES];
	logic [COORD_BITS-1:0] p2x_s1 [NUM_EDGES];
	logic [COORD_BITS-1:0] p2y_s1 [NUM_EDGES];
	logic [COORD_BITS-1:0] tx_s1, ty_s1;
	logic [CNT_BITS-1:0]   cnt_s1;

	// cross tests use origins s0,s0,s1 toward s1,s2,s2
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NUM_EDGES; e++) begin
				logic signed [DIFF_BITS-1:0] dx, dy, vx, vy, ax, ay, ox, oy;
				int n, ao, aa;
				n  = (e + 1) % NUM_EDGES;
				dx = $signed({1'b0, px[n]}) - $signed({1'b0, px[e]});
				dy = $signed({1'b0, py[n]}) - $signed({1'b0, py[e]});
				vx = $signed({1'b0, item.target_x}) - $signed({1'b0, px[e]});
				vy = $signed({1'b0, item.target_y}) - $signed({1'b0, py[e]});
				ao = (e == 2) ? 1 : 0;
				aa = (e == 0) ? 1 : 2;
				ax = $signed({1'b0, px[aa]}) - $signed({1'b0, px[ao]});
				ay = $signed({1'b0, py[aa]}) - $signed({1'b0, py[ao]});
				ox = $signed({1'b0, item.target_x}) - $signed({1'b0, px[ao]});
				oy = $signed({1'b0, item.target_y}) - $signed({1'b0, py[ao]});
				dxvx_s1[e] <= PROD_BITS'(dx) * PROD_BITS'(vx);
				dyvy_s1[e] <= PROD_BITS'(dy) * PROD_BITS'(vy);
				dxdx_s1[e] <= PROD_BITS'(dx) * PROD_BITS'(dx);
				dydy_s1[e] <= PROD_BITS'(dy) * PROD_BITS'(dy);
				cra_s1[e]  <= PROD_BITS'(ax) * PROD_BITS'(oy);
				crb_s1[e]  <= PROD_BITS'(ay) * PROD_BITS'(ox);
				dx_s1[e]   <= dx;
				dy_s1[e]   <= dy;
				p1x_s1[e]  <= px[e];
				p1y_s1[e]  <= py[e];
				p2x_s1[e]  <= px[n];
				p2y_s1[e]  <= py[n];
			end
			tx_s1  <= item.target_x;
			ty_s1  <= item.target_y;
			cnt_s1 <= source_count;
		end
	end

	// stage 2: dot, len2, crosses; set up the divide
	always_ff @(posedge clk) begin
		if (en) begin
			logic sgn [NUM_EDGES];
			for (int e = 0; e < NUM_EDGES; e++) begin
				logic signed [SUM_BITS-1:0] dot, cr;
				logic [LEN_BITS-1:0] len2;
				logic z, lo, hi;
				dot  = SUM_BITS'(dxvx_s1[e]) + SUM_BITS'(dyvy_s1[e]);
				len2 = LEN_BITS'(dxdx_s1[e]) + LEN_BITS'(dydy_s1[e]);
				cr   = SUM_BITS'(cra_s1[e]) - SUM_BITS'(crb_s1[e]);
				sgn[e] = cr > 0;
				z  = len2 == '0;
				lo = z || dot <= 0;
				hi = !lo && dot >= $signed({1'b0, len2});
				w_out[e].wx.mag   <= MAG_BITS'(dx_s1[e] < 0 ? -dx_s1[e] : dx_s1[e]);
				w_out[e].wx.neg   <= dx_s1[e] < 0;
				w_out[e].wy.mag   <= MAG_BITS'(dy_s1[e] < 0 ? -dy_s1[e] : dy_s1[e]);
				w_out[e].wy.neg   <= dy_s1[e] < 0;
				w_out[e].wx.num   <= LEN_BITS'(dot);
				w_out[e].wy.num   <= LEN_BITS'(dot);
				w_out[e].wx.den   <= len2;
				w_out[e].wy.den   <= len2;
				w_out[e].wx.rem   <= '0;
				w_out[e].wy.rem   <= '0;
				w_out[e].wx.q     <= '0;
				w_out[e].wy.q     <= '0;
				w_out[e].wx.base  <= hi ? p2x_s1[e] : p1x_s1[e];
				w_out[e].wy.base  <= hi ? p2y_s1[e] : p1y_s1[e];
				w_out[e].wx.fixed <= lo || hi;
				w_out[e].wy.fixed <= lo || hi;
			end
			c_out.tx <= tx_s1;
			c_out.ty <= ty_s1;
			c_out.in_tri <= (sgn[1] != sgn[0]) && (sgn[2] == sgn[0]);
			case (cnt_s1)
				CNT_SEGMENT:  c_out.status <= ST_SEGMENT;
				CNT_TRIANGLE: c_out.status <= ST_EDGE;
				default:      c_out.status <= ST_UNSUP;
			endcase
		end
	end

endmodule

// ----- src/cgc_back.sv -----
module cgc_back
	import cgc_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  edge_work_t w_in [NUM_EDGES],
	input  ctx_t       c_in,
	output out_item_t  item
);

	logic [COORD_BITS-1:0] rx_s1 [NUM_EDGES];
	logic [COORD_BITS-1:0] ry_s1 [NUM_EDGES];
	ctx_t                  c_s1;
	logic [DIST_BITS-1:0]  d_s2 [NUM_EDGES];
	logic [COORD_BITS-1:0] rx_s2 [NUM_EDGES];
	logic [COORD_BITS-1:0] ry_s2 [NUM_EDGES];
	ctx_t                  c_s2;

	function automatic logic [COORD_BITS-1:0] finish(axis_work_t a);
		logic [MAG_BITS:0] q;
		logic [REM_BITS-1:0] dr;
		q  = a.q;
		dr = {1'b0, a.den} - a.rem;
		if (a.rem >= dr) q = q + 1'b1;
		if (a.fixed) return a.base;
		return a.neg ? COORD_BITS'(a.base - q[COORD_BITS-1:0])
		             : COORD_BITS'(a.base + q[COORD_BITS-1:0]);
	endfunction

	// rounding and final coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NUM_EDGES; e++) begin
				rx_s1[e] <= finish(w_in[e].wx);
				ry_s1[e] <= finish(w_in[e].wy);
			end
			c_s1 <= c_in;
		end
	end

	// squared distances
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NUM_EDGES; e++) begin
				logic signed [DIFF_BITS-1:0] ex, ey;
				ex = $signed({1'b0, c_s1.tx}) - $signed({1'b0, rx_s1[e]});
				ey = $signed({1'b0, c_s1.ty}) - $signed({1'b0, ry_s1[e]});
				d_s2[e] <= DIST_BITS'(ex) * DIST_BITS'(ex) + DIST_BITS'(ey) * DIST_BITS'(ey);
			end
			rx_s2 <= rx_s1;
			ry_s2 <= ry_s1;
			c_s2  <= c_s1;
		end
	end

	// select; first edge wins a tie
	always_ff @(posedge clk) begin
		if (en) begin
			logic [DIST_BITS-1:0] best;
			logic [COORD_BITS-1:0] bx, by;
			best = d_s2[0];
			bx = rx_s2[0];
			by = ry_s2[0];
			for (int e = 1; e < NUM_EDGES; e++) begin
				if (d_s2[e] < best) begin
					best = d_s2[e];
					bx = rx_s2[e];
					by = ry_s2[e];
				end
			end
			item.clip_status <= c_s2.status;
			case (c_s2.status)
				ST_SEGMENT: begin
					item.clipped_x <= rx_s2[0];
					item.clipped_y <= ry_s2[0];
				end
				ST_EDGE: begin
					if (c_s2.in_tri) begin
						item.clipped_x   <= c_s2.tx;
						item.clipped_y   <= c_s2.ty;
						item.clip_status <= ST_INSIDE;
					end else begin
						item.clipped_x <= bx;
						item.clipped_y <= by;
					end
				end
				default: begin
					item.clipped_x <= '0;
					item.clipped_y <= '0;
				end
			endcase
		end
	end

endmodule

// ----- src/chromaticity_gamut_clip_top.sv -----
// Channel | valid    | stall    | payload
// in      | in_valid | in_stall | in_data  (in_item_t: target_x, target_y)
// out     | out_valid| out_stall| out_data (out_item_t: clipped_x, clipped_y, clip_status)
// cfg     | cfg_we   | -        | cfg_index, cfg_data
//
// One transfer per cycle in, one per cycle out, unless held. The pipe is 2 front stages,
// COORD_BITS divide cells and 3 back stages; the divide chain, one quotient
// bit per cell, sets that depth.
// Reset loads the default sources and a count of three and empties the pipe.
// The whole pipe advances together; out_stall with a full output holds it.
module chromaticity_gamut_clip_top
	import cgc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_BITS-1:0]   cfg_data
);

	localparam int DEPTH = 2 + DIV_CELLS + 3;

	logic [CNT_BITS-1:0]   count_q;
	logic [COORD_BITS-1:0] px_q [NUM_EDGES];
	logic [COORD_BITS-1:0] py_q [NUM_EDGES];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_TRIANGLE;
			px_q[0] <= 16'd34073; py_q[0] <= 16'd26467;
			px_q[1] <= 16'd28635; py_q[1] <= 16'd26481;
			px_q[2] <= 16'd18524; py_q[2] <= 16'd15919;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_COUNT: count_q <= cfg_data[CNT_BITS-1:0];
				REG_FIRST_X:      px_q[0] <= cfg_data;
				REG_FIRST_Y:      py_q[0] <= cfg_data;
				REG_SECOND_X:     px_q[1] <= cfg_data;
				REG_SECOND_Y:     py_q[1] <= cfg_data;
				REG_THIRD_X:      px_q[2] <= cfg_data;
				REG_THIRD_Y:      py_q[2] <= cfg_data;
				default:          ;
			endcase
		end
	end

	// advance everything unless a finished result is blocked
	logic adv;
	logic [DEPTH-1:0] vld_q;
	assign adv       = !(vld_q[DEPTH-1] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[DEPTH-2:0], in_valid};
	end

	edge_work_t w [DIV_CELLS+1][NUM_EDGES];
	ctx_t       c [DIV_CELLS+1];

	cgc_front u_front (
		.clk(clk), .en(adv), .item(in_data), .source_count(count_q),
		.px(px_q), .py(py_q), .w_out(w[0]), .c_out(c[0])
	);

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
		cgc_div_cell u_cell (
			.clk(clk), .en(adv), .w_in(w[i]), .c_in(c[i]),
			.w_out(w[i+1]), .c_out(c[i+1])
		);
	end

	cgc_back u_back (
		.clk(clk), .en(adv), .w_in(w[DIV_CELLS]), .c_in(c[DIV_CELLS]),
		.item(out_data)
	);

	// a blocked result must hold the whole pipe
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vld_q))
		else $error("pipe moved under stall");

	// a result with unsupported status carries a zero point
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.clip_status == ST_UNSUP |->
			out_data.clipped_x == '0 && out_data.clipped_y == '0)
		else $error("unsupported count with nonzero point");

	// no transfer in while the pipe is held
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked output");

endmodule
